// File: sv/dix_interval_velocity_unit_assert.svh
// Assertion macros for the interval velocity unit checkers.
`ifndef DIX_INTERVAL_VELOCITY_UNIT_ASSERT_SVH
`define DIX_INTERVAL_VELOCITY_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define DIX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dix check failed");

// Next-cycle implication, off during reset.
`define DIX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dix check failed");

`endif

// File: sv/dix_pkg.sv
package dix_pkg;

  localparam int DEF_AXIS_SIZE = 4096;

  localparam int TI_W       = 12;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_ORIGIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_COUNT   = 3'd4;

  localparam logic [ST_W-1:0] CLAMP_NONE = 2'd0;
  localparam logic [ST_W-1:0] CLAMP_MIN  = 2'd1;
  localparam logic [ST_W-1:0] CLAMP_MAX  = 2'd2;

  // index division: 35-bit numerator, so 35 quotient steps
  localparam int IDX_NUM_W = 35;
  localparam int IDX_SHIFT = 64 - IDX_NUM_W;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_T,
    OP_V,
    OP_VMAX,
    OP_M_VMIN,
    OP_M_VMAX,
    OP_M_VV,
    OP_M_PP,
    OP_M_AL,
    OP_M_AH,
    OP_ACC_A,
    OP_NEG_A,
    OP_M_BL,
    OP_M_BH,
    OP_ACC_B,
    OP_SUB_B,
    OP_DECIDE,
    OP_DIV,
    OP_CLAMP,
    OP_SQRT,
    OP_IDX_INIT,
    OP_IDX_DIV,
    OP_EMIT
  } dix_op_t;

  typedef struct packed {
    dix_op_t op;
  } dix_cmd_t;

  typedef struct packed {
    logic bypass;
  } dix_stat_t;

endpackage

// File: sv/dix_ifs.sv
interface dix_pick_if import dix_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [TI_W-1:0] time_index;
  logic [TI_W-1:0] rms_index;
  logic            start_of_set;

  modport source (output valid, time_index, rms_index, start_of_set, input ready);
  modport sink (input valid, time_index, rms_index, start_of_set, output ready);
endinterface

interface dix_res_if import dix_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [TI_W-1:0] out_time_index;
  logic [TI_W-1:0] interval_index;
  logic [ST_W-1:0] clamp_status;

  modport source (output valid, out_time_index, interval_index, clamp_status, input ready);
  modport sink (input valid, out_time_index, interval_index, clamp_status, output ready);
endinterface

interface dix_cfg_if import dix_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/dix_interval_velocity_unit.sv
// Picks are taken only while idle, and not again until the last result is
// emitted. The Dix quotient is settled without dividing on a zero or negative
// time step, a negative numerator or overflow. Steps: bit-serial quotient
// divider (64 steps), square root (32 steps) and index divider (35).
// Reset (rst_n low, synchronous): controller idle, no result pending, config
// registers to their defaults, previous pick cleared to zero.
module dix_interval_velocity_unit import dix_pkg::*; #(
  parameter int AXIS_SIZE = DEF_AXIS_SIZE
) (
  input logic      clk,
  input logic      rst_n,
  dix_pick_if.sink   in_ch,
  dix_res_if.source  out_ch,
  dix_cfg_if.sink    cfg_ch
);

  dix_cmd_t  cmd;
  dix_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  dix_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  dix_dp #(
    .AXIS_SIZE (AXIS_SIZE)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_ch.valid),
    .cfg_idx            (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .in_time_index      (in_ch.time_index),
    .in_rms_index       (in_ch.rms_index),
    .in_start_of_set    (in_ch.start_of_set),
    .res_time_index     (out_ch.out_time_index),
    .res_interval_index (out_ch.interval_index),
    .res_clamp_status   (out_ch.clamp_status)
  );

endmodule

// File: sv/dix_dp.sv
module dix_dp import dix_pkg::*; #(
  parameter int AXIS_SIZE = DEF_AXIS_SIZE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dix_cmd_t              cmd,
  output dix_stat_t             stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [TI_W-1:0]       in_time_index,
  input  logic [TI_W-1:0]       in_rms_index,
  input  logic                  in_start_of_set,
  output logic [TI_W-1:0]       res_time_index,
  output logic [TI_W-1:0]       res_interval_index,
  output logic [ST_W-1:0]       res_clamp_status
);

  localparam int NC_W = $clog2(AXIS_SIZE + 1);
  localparam logic [63:0] SQ_BIT0 = 64'h4000_0000_0000_0000;

  logic [31:0] time_origin_r;
  logic [30:0] time_step_r;
  logic [30:0] vel_origin_r;
  logic [30:0] vel_step_r;
  logic [12:0] vel_count_r;

  logic [31:0] prev_t_r;
  logic [31:0] prev_v_r;

  logic [TI_W-1:0] ti_r;
  logic [TI_W-1:0] vi_r;
  logic [31:0]     t_r;
  logic [31:0]     v_r;
  logic [31:0]     vmax_r;
  logic [63:0]     p_r;
  logic [63:0]     vmin2_r;
  logic [63:0]     vmax2_r;
  logic [63:0]     sqa_r;
  logic [63:0]     sqb_r;
  logic [95:0]     mag_r;
  logic [127:0]    num_r;
  logic [31:0]     rem_r;
  logic [63:0]     quo_r;
  logic [31:0]     div_d_r;
  logic [63:0]     x_r;
  logic [63:0]     res_r;
  logic [63:0]     bit_r;
  logic [ST_W-1:0] st_r;
  logic [TI_W-1:0] otime_r;
  logic [TI_W-1:0] oidx_r;
  logic [ST_W-1:0] ost_r;

  logic [30:0]          dv;
  logic [NC_W-1:0]      nc;
  logic [NC_W-1:0]      ncm1;
  logic [42:0]          tprod;
  logic [44:0]          tsum;
  logic [31:0]          t_sat;
  logic [42:0]          vprod;
  logic [43:0]          vsum;
  logic [31:0]          v_sat;
  logic [30+NC_W:0]     mprod;
  logic [31+NC_W:0]     msum;
  logic [31:0]          vmax_sat;
  logic [31:0]          abs_t;
  logic [31:0]          abs_pt;
  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [63:0]          p_nxt;
  logic [32:0]          dt;
  logic                 dt_le0;
  logic [63:0]          nhi;
  logic [32:0]          rs;
  logic                 rs_ge;
  logic [32:0]          rs_sub;
  logic [63:0]          sq_sum;
  logic                 sq_ge;
  logic [32:0]          sdiff;
  logic [IDX_NUM_W-1:0] nm;
  logic [IDX_NUM_W-1:0] idx;
  logic                 idx_big;
  logic [IDX_NUM_W-1:0] idx_fin;

  assign dv = (vel_step_r == '0) ? 31'd1 : vel_step_r;

  always_comb begin
    if (vel_count_r == '0) begin
      nc = NC_W'(1);
    end else if (32'(vel_count_r) > 32'(AXIS_SIZE)) begin
      nc = NC_W'(AXIS_SIZE);
    end else begin
      nc = NC_W'(vel_count_r);
    end
  end
  assign ncm1 = nc - NC_W'(1);

  assign tprod = time_step_r * ti_r;
  assign tsum  = {{13{time_origin_r[31]}}, time_origin_r} + {2'b00, tprod};
  always_comb begin
    if (!tsum[44] && (|tsum[43:31])) begin
      t_sat = 32'h7FFF_FFFF;
    end else if (tsum[44] && !(&tsum[43:31])) begin
      t_sat = 32'h8000_0000;
    end else begin
      t_sat = tsum[31:0];
    end
  end

  assign vprod = dv * vi_r;
  assign vsum  = {13'd0, vel_origin_r} + {1'b0, vprod};
  assign v_sat = (|vsum[43:32]) ? 32'hFFFF_FFFF : vsum[31:0];

  assign mprod    = dv * ncm1;
  assign msum     = (32 + NC_W)'(vel_origin_r) + (32 + NC_W)'(mprod);
  assign vmax_sat = (|msum[31+NC_W:32]) ? 32'hFFFF_FFFF : msum[31:0];

  assign abs_t  = t_r[31] ? (~t_r + 32'd1) : t_r;
  assign abs_pt = prev_t_r[31] ? (~prev_t_r + 32'd1) : prev_t_r;

  always_comb begin
    case (cmd.op)
      OP_M_VMIN: begin
        mul_a = {1'b0, vel_origin_r};
        mul_b = {1'b0, vel_origin_r};
      end
      OP_M_VMAX: begin
        mul_a = vmax_r;
        mul_b = vmax_r;
      end
      OP_M_VV: begin
        mul_a = v_r;
        mul_b = v_r;
      end
      OP_M_PP: begin
        mul_a = prev_v_r;
        mul_b = prev_v_r;
      end
      OP_M_AL: begin
        mul_a = sqa_r[31:0];
        mul_b = abs_t;
      end
      OP_M_AH: begin
        mul_a = sqa_r[63:32];
        mul_b = abs_t;
      end
      OP_M_BL: begin
        mul_a = sqb_r[31:0];
        mul_b = abs_pt;
      end
      OP_M_BH: begin
        mul_a = sqb_r[63:32];
        mul_b = abs_pt;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign p_nxt = mul_a * mul_b;

  assign dt     = {t_r[31], t_r} - {prev_t_r[31], prev_t_r};
  assign dt_le0 = dt[32] || (dt == '0);
  assign nhi    = num_r[127:64];
  assign stat.bypass = dt_le0 || num_r[127] || (nhi >= {32'd0, dt[31:0]});

  assign rs     = {rem_r, quo_r[63]};
  assign rs_ge  = rs >= {1'b0, div_d_r};
  assign rs_sub = rs - {1'b0, div_d_r};

  assign sq_sum = res_r + bit_r;
  assign sq_ge  = x_r >= sq_sum;

  assign sdiff = {1'b0, res_r[31:0]} - {2'b00, vel_origin_r};
  assign nm    = {1'b0, sdiff, 1'b0} + IDX_NUM_W'(dv);

  assign idx     = quo_r[IDX_NUM_W-1:0];
  assign idx_big = idx > IDX_NUM_W'(ncm1);
  assign idx_fin = idx_big ? IDX_NUM_W'(ncm1) : idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_origin_r <= '0;
      time_step_r   <= 31'd65536;
      vel_origin_r  <= '0;
      vel_step_r    <= 31'd65536;
      vel_count_r   <= 13'd1;
      prev_t_r      <= '0;
      prev_v_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_TIME_ORIGIN: time_origin_r <= cfg_data;
          CFG_TIME_STEP:   time_step_r   <= cfg_data[30:0];
          CFG_VEL_ORIGIN:  vel_origin_r  <= cfg_data[30:0];
          CFG_VEL_STEP:    vel_step_r    <= cfg_data[30:0];
          CFG_VEL_COUNT:   vel_count_r   <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_LOAD && in_start_of_set) begin
        prev_t_r <= '0;
        prev_v_r <= '0;
      end else if (cmd.op == OP_DECIDE) begin
        prev_t_r <= t_r;
        prev_v_r <= v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    case (cmd.op)
      OP_LOAD: begin
        ti_r <= in_time_index;
        vi_r <= in_rms_index;
      end
      OP_T:      t_r     <= t_sat;
      OP_V:      v_r     <= v_sat;
      OP_VMAX:   vmax_r  <= vmax_sat;
      OP_M_VMAX: vmin2_r <= p_r;
      OP_M_VV:   vmax2_r <= p_r;
      OP_M_PP:   sqa_r   <= p_r;
      OP_M_AL:   sqb_r   <= p_r;
      OP_M_AH:   mag_r   <= {32'd0, p_r};
      OP_ACC_A:  mag_r   <= mag_r + {p_r, 32'd0};
      OP_NEG_A:  num_r   <= t_r[31] ? (128'd0 - {32'd0, mag_r}) : {32'd0, mag_r};
      OP_M_BH:   mag_r   <= {32'd0, p_r};
      OP_ACC_B:  mag_r   <= mag_r + {p_r, 32'd0};
      OP_SUB_B: begin
        num_r <= prev_t_r[31] ? (num_r + {32'd0, mag_r}) : (num_r - {32'd0, mag_r});
      end
      OP_DECIDE: begin
        res_r <= '0;
        bit_r <= SQ_BIT0;
        if (dt_le0) begin
          x_r  <= vmax2_r;
          st_r <= CLAMP_MAX;
        end else if (num_r[127]) begin
          x_r  <= vmin2_r;
          st_r <= CLAMP_MIN;
        end else if (nhi >= {32'd0, dt[31:0]}) begin
          x_r  <= vmax2_r;
          st_r <= CLAMP_MAX;
        end else begin
          st_r <= CLAMP_NONE;
        end
        rem_r   <= nhi[31:0];
        quo_r   <= num_r[63:0];
        div_d_r <= dt[31:0];
      end
      OP_DIV, OP_IDX_DIV: begin
        rem_r <= rs_ge ? rs_sub[31:0] : rs[31:0];
        quo_r <= {quo_r[62:0], rs_ge};
      end
      OP_CLAMP: begin
        res_r <= '0;
        bit_r <= SQ_BIT0;
        if (quo_r < vmin2_r) begin
          x_r  <= vmin2_r;
          st_r <= CLAMP_MIN;
        end else if (quo_r > vmax2_r) begin
          x_r  <= vmax2_r;
          st_r <= CLAMP_MAX;
        end else begin
          x_r <= quo_r;
        end
      end
      OP_SQRT: begin
        if (sq_ge) begin
          x_r   <= x_r - sq_sum;
          res_r <= {1'b0, res_r[63:1]} + bit_r;
        end else begin
          res_r <= {1'b0, res_r[63:1]};
        end
        bit_r <= {2'b00, bit_r[63:2]};
      end
      OP_IDX_INIT: begin
        rem_r   <= '0;
        div_d_r <= {dv, 1'b0};
        if ({1'b0, res_r[31:0]} > {2'b00, vel_origin_r}) begin
          quo_r <= {nm, {IDX_SHIFT{1'b0}}};
        end else begin
          quo_r <= '0;
        end
      end
      OP_EMIT: begin
        otime_r <= ti_r;
        oidx_r  <= idx_fin[TI_W-1:0];
        ost_r   <= idx_big ? CLAMP_MAX : st_r;
      end
      default: ;
    endcase
  end

  assign res_time_index     = otime_r;
  assign res_interval_index = oidx_r;
  assign res_clamp_status   = ost_r;

endmodule

// File: sv/dix_ctrl.sv
module dix_ctrl import dix_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output dix_cmd_t  cmd,
  input  dix_stat_t stat
);

  localparam logic [5:0] CNT_DIV  = 6'd63;
  localparam logic [5:0] CNT_SQRT = 6'd31;
  localparam logic [5:0] CNT_IDX  = 6'(IDX_NUM_W - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_T, S_V, S_VMAX, S_M_VMIN, S_M_VMAX, S_M_VV, S_M_PP,
    S_M_AL, S_M_AH, S_ACC_A, S_NEG_A, S_M_BL, S_M_BH, S_ACC_B, S_SUB_B,
    S_DECIDE, S_DIV, S_CLAMP, S_SQRT, S_IDX_INIT, S_IDX_DIV, S_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       emit_ok;

  assign emit_ok = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_T;
        end
      end
      S_T:      begin cmd.op = OP_T;      state_nxt = S_V;      end
      S_V:      begin cmd.op = OP_V;      state_nxt = S_VMAX;   end
      S_VMAX:   begin cmd.op = OP_VMAX;   state_nxt = S_M_VMIN; end
      S_M_VMIN: begin cmd.op = OP_M_VMIN; state_nxt = S_M_VMAX; end
      S_M_VMAX: begin cmd.op = OP_M_VMAX; state_nxt = S_M_VV;   end
      S_M_VV:   begin cmd.op = OP_M_VV;   state_nxt = S_M_PP;   end
      S_M_PP:   begin cmd.op = OP_M_PP;   state_nxt = S_M_AL;   end
      S_M_AL:   begin cmd.op = OP_M_AL;   state_nxt = S_M_AH;   end
      S_M_AH:   begin cmd.op = OP_M_AH;   state_nxt = S_ACC_A;  end
      S_ACC_A:  begin cmd.op = OP_ACC_A;  state_nxt = S_NEG_A;  end
      S_NEG_A:  begin cmd.op = OP_NEG_A;  state_nxt = S_M_BL;   end
      S_M_BL:   begin cmd.op = OP_M_BL;   state_nxt = S_M_BH;   end
      S_M_BH:   begin cmd.op = OP_M_BH;   state_nxt = S_ACC_B;  end
      S_ACC_B:  begin cmd.op = OP_ACC_B;  state_nxt = S_SUB_B;  end
      S_SUB_B:  begin cmd.op = OP_SUB_B;  state_nxt = S_DECIDE; end
      S_DECIDE: begin
        cmd.op = OP_DECIDE;
        if (stat.bypass) begin
          cnt_nxt   = CNT_SQRT;
          state_nxt = S_SQRT;
        end else begin
          cnt_nxt   = CNT_DIV;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.op    = OP_CLAMP;
        cnt_nxt   = CNT_SQRT;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = OP_SQRT;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          state_nxt = S_IDX_INIT;
        end
      end
      S_IDX_INIT: begin
        cmd.op    = OP_IDX_INIT;
        cnt_nxt   = CNT_IDX;
        state_nxt = S_IDX_DIV;
      end
      S_IDX_DIV: begin
        cmd.op  = OP_IDX_DIV;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_ok) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: sv/dix_chk.sv
`include "dix_interval_velocity_unit_assert.svh"

module dix_chk import dix_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [TI_W-1:0] out_time_index,
  input logic [TI_W-1:0] out_interval_index,
  input logic [ST_W-1:0] out_clamp_status
);

  `DIX_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `DIX_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_time_index) && $stable(out_interval_index) && $stable(out_clamp_status))
  `DIX_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)
  `DIX_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, out_clamp_status == CLAMP_NONE || out_clamp_status == CLAMP_MIN || out_clamp_status == CLAMP_MAX)
  `DIX_ASSERT_IMP(a_min_is_zero, clk, rst_n, out_valid && out_clamp_status == CLAMP_MIN, out_interval_index == '0)

endmodule

bind dix_interval_velocity_unit dix_chk u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_time_index     (out_ch.out_time_index),
  .out_interval_index (out_ch.interval_index),
  .out_clamp_status   (out_ch.clamp_status)
);
